// File: hw/rtl/mbt_pkg.sv
// ----------------------------------------------------------------------------
// mbt_pkg: shared types and constants of the mru bond table
// command codes, datapath operations, datapath status and read selects
// ----------------------------------------------------------------------------
package mbt_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = 4;
    localparam int CMD_W   = 3;
    localparam int ADDR_W  = 48;
    localparam int STAMP_W = 32;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(ENTRIES - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_FIND       = 3'd0,
        CMD_ADD        = 3'd1,
        CMD_TOUCH      = 3'd2,
        CMD_FORGET     = 3'd3,
        CMD_FORGET_ALL = 3'd4,
        CMD_GET        = 3'd5
    } t_cmd;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_SCAN,
        OP_BUMP,
        OP_APPEND,
        OP_CLEAR,
        OP_MOVE_L,
        OP_MOVE_R,
        OP_SHIFT,
        OP_LOAD_OUT
    } t_dp_op;

    typedef enum logic [1:0] {
        RD_CUR,
        RD_PREV,
        RD_NEXT,
        RD_POS
    } t_rd_sel;

    typedef struct packed {
        t_dp_op  op;
        t_rd_sel rd_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             hit;
        logic             match;
        logic             scan_last;
        logic             can_l;
        logic             place_l;
        logic             can_r;
        logic             at_end;
        logic             out_free;
    } t_dp_stat;

endpackage

// File: hw/rtl/mbt_ctrl.sv
// ----------------------------------------------------------------------------
// mbt_ctrl: command sequencer of the mru bond table
// walks scan, decision, reposition or compaction, and result load
// ----------------------------------------------------------------------------
module mbt_ctrl
    import mbt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output logic     o_idle,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_ACT    = 7'b0000100,
        S_MOVE_L = 7'b0001000,
        S_MOVE_R = 7'b0010000,
        S_SHIFT  = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;

        // read select depends on state only
        unique case (r_state)
            S_MOVE_L:          o_cmd.rd_sel = RD_PREV;
            S_MOVE_R, S_SHIFT: o_cmd.rd_sel = RD_NEXT;
            S_DONE:            o_cmd.rd_sel = RD_POS;
            default:           o_cmd.rd_sel = RD_CUR;
        endcase

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LATCH;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.op = OP_SCAN;
                if (i_stat.match || i_stat.scan_last) begin
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                unique case (i_stat.cmd)
                    CMD_ADD: begin
                        o_cmd.op = i_stat.hit ? OP_BUMP : OP_APPEND;
                        n_state  = S_MOVE_L;
                    end
                    CMD_TOUCH: begin
                        if (i_stat.hit) begin
                            o_cmd.op = OP_BUMP;
                            n_state  = S_MOVE_L;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    CMD_FORGET: begin
                        n_state = i_stat.hit ? S_SHIFT : S_DONE;
                    end
                    CMD_FORGET_ALL: begin
                        o_cmd.op = OP_CLEAR;
                        n_state  = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_MOVE_L: begin
                o_cmd.op = OP_MOVE_L;
                if (!i_stat.can_l) begin
                    n_state = i_stat.place_l ? S_DONE : S_MOVE_R;
                end
            end
            S_MOVE_R: begin
                o_cmd.op = OP_MOVE_R;
                if (!i_stat.can_r) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                o_cmd.op = OP_SHIFT;
                if (i_stat.at_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_LOAD_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

// File: hw/rtl/mbt_datapath.sv
// ----------------------------------------------------------------------------
// mbt_datapath: slot storage, use counter and result register
// one read port and one write port on the slot array per cycle
// ----------------------------------------------------------------------------
module mbt_datapath
    import mbt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [ADDR_W-1:0]  i_device_address,
    input  logic [IDX_W-1:0]   i_position_in,
    input  logic               i_out_ready,
    output t_dp_stat           o_stat,
    output logic               o_out_valid,
    output logic               o_status,
    output logic [IDX_W-1:0]   o_position_out,
    output logic [ADDR_W-1:0]  o_entry_address,
    output logic [STAMP_W-1:0] o_entry_stamp,
    output logic [CNT_W-1:0]   o_entry_count
);

    logic [ADDR_W-1:0]  r_slot_addr  [ENTRIES];
    logic [STAMP_W-1:0] r_slot_stamp [ENTRIES];

    logic [CNT_W-1:0]   r_count;
    logic [STAMP_W-1:0] r_tally;
    logic [IDX_W-1:0]   r_idx;
    logic               r_hit;
    logic               r_moved;
    logic [CMD_W-1:0]   r_cmd;
    logic [ADDR_W-1:0]  r_key;
    logic [IDX_W-1:0]   r_pos;
    logic [STAMP_W-1:0] r_mov_stamp;

    logic               r_out_valid;
    logic               r_out_status;
    logic [IDX_W-1:0]   r_out_pos;
    logic [ADDR_W-1:0]  r_out_addr;
    logic [STAMP_W-1:0] r_out_stamp;
    logic [CNT_W-1:0]   r_out_count;

    logic [IDX_W-1:0]   rd_idx;
    logic [ADDR_W-1:0]  rd_addr;
    logic [STAMP_W-1:0] rd_stamp;
    logic [CNT_W-1:0]   idx_ext;
    logic               in_range;
    logic               at_end;
    logic               match;
    logic               can_l;
    logic               can_r;
    logic               place_l;
    logic               out_free;
    logic [STAMP_W-1:0] tally_inc;

    logic               n_out_status;
    logic [IDX_W-1:0]   n_out_pos;
    logic [ADDR_W-1:0]  n_out_addr;
    logic [STAMP_W-1:0] n_out_stamp;

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_PREV: rd_idx = r_idx - IDX_W'(1);
            RD_NEXT: rd_idx = r_idx + IDX_W'(1);
            RD_POS:  rd_idx = r_pos;
            default: rd_idx = r_idx;
        endcase
    end

    assign rd_addr  = r_slot_addr[rd_idx];
    assign rd_stamp = r_slot_stamp[rd_idx];

    assign idx_ext   = {1'b0, r_idx};
    assign in_range  = idx_ext < r_count;
    assign at_end    = (idx_ext + CNT_W'(1)) >= r_count;
    assign match     = in_range && (rd_addr == r_key);
    // insertion step: newer stamp passes strictly older ones
    assign can_l     = (r_idx != '0) && (rd_stamp < r_mov_stamp);
    assign can_r     = !at_end && (rd_stamp > r_mov_stamp);
    assign place_l   = r_moved || at_end;
    assign out_free  = !r_out_valid || i_out_ready;
    assign tally_inc = r_tally + STAMP_W'(1);

    always_comb begin
        o_stat.cmd       = r_cmd;
        o_stat.hit       = r_hit;
        o_stat.match     = match;
        o_stat.scan_last = at_end;
        o_stat.can_l     = can_l;
        o_stat.place_l   = place_l;
        o_stat.can_r     = can_r;
        o_stat.at_end    = at_end;
        o_stat.out_free  = out_free;
    end

    // result fields
    always_comb begin
        n_out_status = 1'b0;
        n_out_pos    = '0;
        n_out_addr   = '0;
        n_out_stamp  = '0;
        unique case (r_cmd)
            CMD_FIND: begin
                n_out_status = !r_hit;
                n_out_pos    = r_hit ? r_idx : '0;
            end
            CMD_ADD: begin
                n_out_status = 1'b0;
            end
            CMD_TOUCH, CMD_FORGET: begin
                n_out_status = !r_hit;
            end
            CMD_FORGET_ALL: begin
                n_out_status = 1'b0;
            end
            CMD_GET: begin
                n_out_pos = r_pos;
                if ({1'b0, r_pos} < r_count) begin
                    n_out_addr  = rd_addr;
                    n_out_stamp = rd_stamp;
                end else begin
                    n_out_status = 1'b1;
                end
            end
            default: begin
                n_out_status = 1'b1;
            end
        endcase
    end

    // payload: slots, latched item, result
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LATCH: begin
                r_cmd <= i_command;
                r_key <= i_device_address;
                r_pos <= i_position_in;
            end
            OP_BUMP, OP_APPEND: begin
                r_mov_stamp <= tally_inc;
            end
            OP_MOVE_L: begin
                if (can_l) begin
                    r_slot_addr[r_idx]  <= rd_addr;
                    r_slot_stamp[r_idx] <= rd_stamp;
                end else if (place_l) begin
                    r_slot_addr[r_idx]  <= r_key;
                    r_slot_stamp[r_idx] <= r_mov_stamp;
                end
            end
            OP_MOVE_R: begin
                if (can_r) begin
                    r_slot_addr[r_idx]  <= rd_addr;
                    r_slot_stamp[r_idx] <= rd_stamp;
                end else begin
                    r_slot_addr[r_idx]  <= r_key;
                    r_slot_stamp[r_idx] <= r_mov_stamp;
                end
            end
            OP_SHIFT: begin
                if (!at_end) begin
                    r_slot_addr[r_idx]  <= rd_addr;
                    r_slot_stamp[r_idx] <= rd_stamp;
                end
            end
            OP_LOAD_OUT: begin
                r_out_status <= n_out_status;
                r_out_pos    <= n_out_pos;
                r_out_addr   <= n_out_addr;
                r_out_stamp  <= n_out_stamp;
                r_out_count  <= r_count;
            end
            default: begin
            end
        endcase
    end

    // control: count, use counter, slot index, flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_tally     <= '0;
            r_idx       <= '0;
            r_hit       <= 1'b0;
            r_moved     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                OP_LATCH: begin
                    r_idx <= '0;
                    r_hit <= 1'b0;
                end
                OP_SCAN: begin
                    if (match) begin
                        r_hit <= 1'b1;
                    end else if (!at_end) begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                OP_BUMP: begin
                    r_tally <= tally_inc;
                    r_moved <= 1'b0;
                end
                OP_APPEND: begin
                    r_tally <= tally_inc;
                    r_moved <= 1'b0;
                    if (r_count == FULL_COUNT) begin
                        // full table: the oldest entry in the last slot is dropped
                        r_idx <= LAST_IDX;
                    end else begin
                        r_idx   <= r_count[IDX_W-1:0];
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                OP_CLEAR: begin
                    r_count <= '0;
                end
                OP_MOVE_L: begin
                    if (can_l) begin
                        r_idx   <= r_idx - IDX_W'(1);
                        r_moved <= 1'b1;
                    end
                end
                OP_MOVE_R: begin
                    if (can_r) begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                OP_SHIFT: begin
                    if (!at_end) begin
                        r_idx <= r_idx + IDX_W'(1);
                    end else begin
                        r_count <= r_count - CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase

            if (i_cmd.op == OP_LOAD_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_position_out  = r_out_pos;
    assign o_entry_address = r_out_addr;
    assign o_entry_stamp   = r_out_stamp;
    assign o_entry_count   = r_out_count;

endmodule

// File: hw/rtl/mru_bond_table_core.sv
// ----------------------------------------------------------------------------
// mru_bond_table_core: most recently used table of 48-bit device addresses
// sequence: a slot scan that visits the slots in order (at least one, up to
// count), then the reposition or compaction pass, then the result load
// throughput: one command at a time; the next input beat is taken only after
// the result is loaded, which waits until the output register is free
// reset: synchronous active low, empties the table and clears the use counter
// ----------------------------------------------------------------------------
module mru_bond_table_core
    import mbt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beat
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,   // device_address[47:0], position_in[50:48], zero pad
    input  logic [2:0]  i_s_tuser,   // command[2:0]
    // result beat
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [87:0] o_m_tdata,   // position_out[2:0], entry_address[50:3],
                                     // entry_stamp[82:51], entry_count[86:83], zero pad
    output logic [0:0]  o_m_tuser    // status[0]
);

    t_dp_cmd            dp_cmd;
    t_dp_stat           dp_stat;
    logic               idle;
    logic               start;
    logic               res_status;
    logic [IDX_W-1:0]   res_pos;
    logic [ADDR_W-1:0]  res_addr;
    logic [STAMP_W-1:0] res_stamp;
    logic [CNT_W-1:0]   res_count;

    // a new command is taken only while the sequencer is idle and out of reset;
    // a finished result can still sit in the output register waiting for its
    // consumer
    assign o_s_tready = idle && i_rst_n;
    assign start      = i_s_tvalid && o_s_tready;

    mbt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_idle  (idle),
        .o_cmd   (dp_cmd)
    );

    // slots stay sorted newest stamp first; add and touch move one entry
    // left past older stamps, or right past newer ones after a counter wrap
    mbt_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_command        (i_s_tuser),
        .i_device_address (i_s_tdata[47:0]),
        .i_position_in    (i_s_tdata[50:48]),
        .i_out_ready      (i_m_tready),
        .o_stat           (dp_stat),
        .o_out_valid      (o_m_tvalid),
        .o_status         (res_status),
        .o_position_out   (res_pos),
        .o_entry_address  (res_addr),
        .o_entry_stamp    (res_stamp),
        .o_entry_count    (res_count)
    );

    // entry_count is captured with the rest of the result, so a following
    // command accepted while this beat waits cannot change it
    assign o_m_tdata = {1'b0, res_count, res_stamp, res_addr, res_pos};
    assign o_m_tuser = res_status;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for mru_bond_table_core
// drives command beats with random gaps and result back-pressure, keeps its
// own copy of the ordered address table and compares every result beat field
// by field against the predicted one
// ----------------------------------------------------------------------------
module testbench
    import mbt_pkg::*;
();

    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          DRAIN_CYCLES   = 50;
    localparam logic [2:0]  CMD_SPARE_6    = 3'd6;
    localparam logic [2:0]  CMD_SPARE_7    = 3'd7;
    localparam logic        STATUS_OK      = 1'b0;
    localparam logic        STATUS_MISS    = 1'b1;
    localparam logic [47:0] ADDR_ONES      = {ADDR_W{1'b1}};

    typedef struct packed {
        logic               status;
        logic [2:0]         position;
        logic [ADDR_W-1:0]  address;
        logic [STAMP_W-1:0] stamp;
        logic [CNT_W-1:0]   count;
    } t_bond_reply;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [55:0] i_s_tdata  = '0;   // device_address[47:0], position_in[50:48], zero pad
    logic [2:0]  i_s_tuser  = '0;   // command[2:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [87:0] o_m_tdata;         // position_out[2:0], entry_address[50:3],
                                    // entry_stamp[82:51], entry_count[86:83], zero pad
    logic [0:0]  o_m_tuser;         // status[0]

    mru_bond_table_core dut (.*);

    // shadow of the table
    logic [ADDR_W-1:0]  tbl_addr  [ENTRIES];
    logic [STAMP_W-1:0] tbl_stamp [ENTRIES];
    int                 tbl_count;
    logic [STAMP_W-1:0] use_tally;

    t_bond_reply due_replies [$];
    int          mismatches   = 0;
    int          quiet_cycles = 0;
    bit          src_gaps     = 1'b1;
    bit          sink_stalls  = 1'b1;
    logic [ADDR_W-1:0] addr_pool [12];

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void wipe_table();
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_addr[i]  = '0;
            tbl_stamp[i] = '0;
        end
        tbl_count = 0;
    endfunction

    function automatic int slot_of(logic [ADDR_W-1:0] addr);
        for (int i = 0; i < tbl_count && i < ENTRIES; i++) begin
            if (tbl_addr[i] == addr) return i;
        end
        return -1;
    endfunction

    // stable insertion pass, newest stamp first
    function automatic void sort_by_stamp();
        logic [ADDR_W-1:0]  ka;
        logic [STAMP_W-1:0] ks;
        int                 j;
        for (int i = 1; i < tbl_count && i < ENTRIES; i++) begin
            ka = tbl_addr[i];
            ks = tbl_stamp[i];
            j  = i;
            while (j > 0 && tbl_stamp[j-1] < ks) begin
                tbl_addr[j]  = tbl_addr[j-1];
                tbl_stamp[j] = tbl_stamp[j-1];
                j--;
            end
            tbl_addr[j]  = ka;
            tbl_stamp[j] = ks;
        end
    endfunction

    function automatic t_bond_reply apply_command(logic [2:0] cmd, logic [ADDR_W-1:0] addr,
                                                  logic [2:0] pos);
        t_bond_reply r;
        int          hit;
        r   = '0;
        hit = slot_of(addr);
        case (cmd)
            CMD_FIND: begin
                if (hit < 0) r.status = STATUS_MISS;
                else         r.position = hit[2:0];
            end
            CMD_ADD: begin
                use_tally = use_tally + 1'b1;
                if (hit >= 0) begin
                    tbl_stamp[hit] = use_tally;
                end else begin
                    // full table: the oldest entry gives way
                    if (tbl_count >= ENTRIES) tbl_count = ENTRIES - 1;
                    tbl_addr[tbl_count]  = addr;
                    tbl_stamp[tbl_count] = use_tally;
                    tbl_count++;
                end
                sort_by_stamp();
            end
            CMD_TOUCH: begin
                if (hit < 0) begin
                    r.status = STATUS_MISS;
                end else begin
                    use_tally      = use_tally + 1'b1;
                    tbl_stamp[hit] = use_tally;
                    sort_by_stamp();
                end
            end
            CMD_FORGET: begin
                if (hit < 0) begin
                    r.status = STATUS_MISS;
                end else begin
                    for (int j = hit; j + 1 < tbl_count && j + 1 < ENTRIES; j++) begin
                        tbl_addr[j]  = tbl_addr[j+1];
                        tbl_stamp[j] = tbl_stamp[j+1];
                    end
                    tbl_count--;
                    tbl_addr[tbl_count]  = '0;
                    tbl_stamp[tbl_count] = '0;
                end
            end
            CMD_FORGET_ALL: wipe_table();
            CMD_GET: begin
                r.position = pos;
                if (pos >= tbl_count) begin
                    r.status = STATUS_MISS;
                end else begin
                    r.address = tbl_addr[pos];
                    r.stamp   = tbl_stamp[pos];
                end
            end
            default: r.status = STATUS_MISS;
        endcase
        r.count = tbl_count[CNT_W-1:0];
        return r;
    endfunction

    // one command beat; handshake sampled at the falling edge, taken at the next rise
    task automatic send_command(input logic [2:0] cmd, input logic [ADDR_W-1:0] addr,
                                input logic [2:0] pos);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'b0, pos, addr};
        i_s_tuser  <= cmd;
        do @(negedge i_clk); while (!o_s_tready);
        @(posedge i_clk);
        due_replies.push_back(apply_command(cmd, addr, pos));
    endtask

    task automatic hold_until_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (due_replies.size() != 0);
    endtask

    function automatic logic [2:0] pick_command();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35) return CMD_ADD;
        if (roll < 50) return CMD_FIND;
        if (roll < 65) return CMD_TOUCH;
        if (roll < 77) return CMD_FORGET;
        if (roll < 95) return CMD_GET;
        if (roll < 98) return CMD_FORGET_ALL;
        return (roll == 98) ? CMD_SPARE_6 : CMD_SPARE_7;
    endfunction

    // mostly keys from a small pool so that hits, refreshes and evictions happen
    task automatic send_random(input int n);
        logic [ADDR_W-1:0] addr;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) addr = ADDR_W'({$urandom(), $urandom()});
            else                           addr = addr_pool[$urandom_range(0, 11)];
            send_command(pick_command(), addr, 3'($urandom_range(0, 7)));
        end
    endtask

    function automatic void refill_pool();
        for (int i = 0; i < 12; i++) addr_pool[i] = ADDR_W'({$urandom(), $urandom()});
    endfunction

    task automatic test_directed();
        send_command(CMD_GET, '0, 3'd7);            // get on empty table
        send_command(CMD_FIND, '0, 3'd0);           // find miss
        send_command(CMD_ADD, '0, 3'd0);
        send_command(CMD_ADD, ADDR_ONES, 3'd7);
        send_command(CMD_FIND, ADDR_ONES, 3'd0);
        send_command(CMD_TOUCH, '0, 3'd0);
        send_command(CMD_TOUCH, 48'h1234_5678_9ABC, 3'd0);  // touch miss
        send_command(CMD_FORGET, 48'h1234_5678_9ABC, 3'd0); // forget miss
        // fill up, then one more add evicts the oldest
        for (int i = 1; i <= 7; i++) send_command(CMD_ADD, 48'hA5A5_0000_0000 | i, 3'd0);
        send_command(CMD_ADD, '0, 3'd0);            // refresh of a present key
        send_command(CMD_GET, '0, 3'd0);
        send_command(CMD_GET, '0, 3'd7);
        send_command(CMD_FORGET, 48'hA5A5_0000_0004, 3'd0); // gap closes in the middle
        send_command(CMD_GET, ADDR_ONES, 3'd7);     // position beyond count
        send_command(CMD_SPARE_6, ADDR_ONES, 3'd7);
        send_command(CMD_SPARE_7, '0, 3'd0);
        send_command(CMD_FORGET_ALL, '0, 3'd0);
        send_command(CMD_GET, '0, 3'd0);
    endtask

    task automatic test_random_mix();
        for (int round = 0; round < 5; round++) begin
            refill_pool();
            send_random(110);
        end
    endtask

    task automatic test_pause_to_empty();
        send_random(30);
        hold_until_drained();
        send_random(30);
    endtask

    task automatic test_full_rate();
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        refill_pool();
        send_random(120);
    endtask

    // result side back-pressure
    initial begin
        forever begin
            @(posedge i_clk);
            if (sink_stalls && $urandom_range(0, 7) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    // result beats are compared at the falling edge before they are taken
    always @(negedge i_clk) begin
        t_bond_reply want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (due_replies.size() == 0) begin
                $error("result beat with nothing outstanding");
                mismatches++;
            end else begin
                want = due_replies.pop_front();
                if (o_m_tuser[0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_m_tuser[0]);
                    mismatches++;
                end
                if (o_m_tdata[2:0] !== want.position) begin
                    $error("position_out: expected %0d, got %0d", want.position,
                           o_m_tdata[2:0]);
                    mismatches++;
                end
                if (o_m_tdata[50:3] !== want.address) begin
                    $error("entry_address: expected %h, got %h", want.address,
                           o_m_tdata[50:3]);
                    mismatches++;
                end
                if (o_m_tdata[82:51] !== want.stamp) begin
                    $error("entry_stamp: expected %h, got %h", want.stamp, o_m_tdata[82:51]);
                    mismatches++;
                end
                if (o_m_tdata[86:83] !== want.count) begin
                    $error("entry_count: expected %0d, got %0d", want.count,
                           o_m_tdata[86:83]);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(negedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        wipe_table();
        use_tally = '0;
        refill_pool();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_mix();
        test_pause_to_empty();
        test_full_rate();

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && due_replies.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
